[hdl/agc_pkg.sv]
// ============================================================================
// agc_pkg
// Shared constants and types for the arrow glyph coverage pipeline.
// ============================================================================
package agc_pkg;

    // Fixed point format of all geometry: 8 fraction bits.
    localparam int FRAC_BITS = 8;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int MAX_CELL  = 256;

    // Scale factors with 16 fraction bits.
    localparam int K_MARGIN = 9175;
    localparam int K_HALF   = 3408;
    localparam int K_WING   = 39322;

    // Arrow directions.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_CELL_SIZE = 1'b1;

    // Widths of coordinates and distances.
    localparam int COORD_W = 17;
    localparam int DIST_W  = 18;

    // Pipeline depths.
    localparam int PIX_LAT  = 4;
    localparam int SEG_LAT  = 20;
    localparam int PIPE_LAT = PIX_LAT + SEG_LAT + 2;

    // End points of one stroke.
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } seg_ends_t;

    // Geometry derived from the configuration.
    typedef struct packed {
        seg_ends_t [2:0]   seg;
        logic [11:0]       half;
        logic [DIST_W-1:0] dinit;
    } geom_t;

endpackage

[hdl/agc_geom.sv]
// ============================================================================
// agc_geom
// Configuration registers and the registered arrow geometry derived from them.
// ============================================================================
module agc_geom
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [8:0]           cfg_data,
    output agc_pkg::geom_t       geom
);

    logic [1:0]  direction_reg;
    logic [8:0]  cell_size_reg;

    logic [8:0]  n_c;
    logic [21:0] m_prod_c;
    logic [19:0] h_prod_c;

    logic [13:0] m_reg;
    logic [11:0] half1_reg;
    logic [15:0] mid1_reg;
    logic [16:0] nq1_reg;

    logic [15:0] diff_c;
    logic [31:0] w_prod_c;
    logic [32:0] w_round_c;

    logic [13:0] wing_reg;
    logic [16:0] lo_reg;
    logic [16:0] hi_reg;
    logic [16:0] mid2_reg;
    logic [11:0] half2_reg;
    logic [17:0] dinit2_reg;

    agc_pkg::geom_t geom_next;
    agc_pkg::geom_t geom_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= agc_pkg::DIR_RIGHT;
            cell_size_reg <= 9'd128;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                agc_pkg::CFG_DIRECTION: direction_reg <= cfg_data[1:0];
                agc_pkg::CFG_CELL_SIZE: cell_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cell size limited to 1..MAX_CELL, then margin and half width.
    always_comb
    begin
        if (cell_size_reg == 9'd0)
            n_c = 9'd1;
        else if (cell_size_reg > 9'(agc_pkg::MAX_CELL))
            n_c = 9'(agc_pkg::MAX_CELL);
        else
            n_c = cell_size_reg;
        m_prod_c = 22'(n_c) * 22'(agc_pkg::K_MARGIN) + 22'(agc_pkg::ONE_Q / 2);
        h_prod_c = 20'(n_c) * 20'(agc_pkg::K_HALF) + 20'(agc_pkg::ONE_Q / 2);
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_prod_c[21:8];
        half1_reg <= h_prod_c[19:8];
        mid1_reg  <= {n_c, 7'd0};
        nq1_reg   <= {n_c, 8'd0};
    end

    // Wing reach and the low and high ends of the shaft.
    always_comb
    begin
        diff_c    = mid1_reg - 16'(m_reg);
        w_prod_c  = 32'(diff_c) * 32'(agc_pkg::K_WING);
        w_round_c = {1'b0, w_prod_c} + 33'd32768;
    end

    always_ff @(posedge clk)
    begin
        wing_reg   <= w_round_c[29:16];
        lo_reg     <= 17'(m_reg);
        hi_reg     <= nq1_reg - 17'(m_reg);
        mid2_reg   <= 17'(mid1_reg);
        half2_reg  <= half1_reg;
        dinit2_reg <= {nq1_reg, 1'b0};
    end

    // Stroke end points for the chosen direction.
    always_comb
    begin
        logic [16:0] w;
        w = 17'(wing_reg);
        geom_next.half  = half2_reg;
        geom_next.dinit = dinit2_reg;
        case (direction_reg)
            agc_pkg::DIR_UP:
            begin
                geom_next.seg[0] = '{mid2_reg, hi_reg, mid2_reg, lo_reg};
                geom_next.seg[1] = '{mid2_reg, lo_reg, mid2_reg - w, lo_reg + w};
                geom_next.seg[2] = '{mid2_reg, lo_reg, mid2_reg + w, lo_reg + w};
            end
            agc_pkg::DIR_DOWN:
            begin
                geom_next.seg[0] = '{mid2_reg, lo_reg, mid2_reg, hi_reg};
                geom_next.seg[1] = '{mid2_reg, hi_reg, mid2_reg - w, hi_reg - w};
                geom_next.seg[2] = '{mid2_reg, hi_reg, mid2_reg + w, hi_reg - w};
            end
            agc_pkg::DIR_LEFT:
            begin
                geom_next.seg[0] = '{hi_reg, mid2_reg, lo_reg, mid2_reg};
                geom_next.seg[1] = '{lo_reg, mid2_reg, lo_reg + w, mid2_reg - w};
                geom_next.seg[2] = '{lo_reg, mid2_reg, lo_reg + w, mid2_reg + w};
            end
            default:
            begin
                geom_next.seg[0] = '{lo_reg, mid2_reg, hi_reg, mid2_reg};
                geom_next.seg[1] = '{hi_reg, mid2_reg, hi_reg - w, mid2_reg - w};
                geom_next.seg[2] = '{hi_reg, mid2_reg, hi_reg - w, mid2_reg + w};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

[hdl/agc_seg.sv]
// ============================================================================
// agc_seg
// Pipelined point-to-segment distance: projection, 16-bit long division,
// closest point and integer square root, twenty register stages.
// ============================================================================
module agc_seg
(
    input  logic                          clk,
    input  logic                          en,
    input  agc_pkg::seg_ends_t            ends,
    input  logic [agc_pkg::COORD_W-1:0]   px,
    input  logic [agc_pkg::COORD_W-1:0]   py,
    output logic [agc_pkg::DIST_W-1:0]    distance
);

    localparam int DIV_ST = 8;
    localparam int DIV_PER = 16 / DIV_ST;
    localparam int SQ_ST  = 6;
    localparam int SQ_PER = 18 / SQ_ST;

    typedef struct packed {
        logic [16:0]        ax;
        logic [16:0]        ay;
        logic signed [17:0] vx;
        logic signed [17:0] vy;
        logic [16:0]        px;
        logic [16:0]        py;
    } seg_carry_t;

    // Stage 1: direction vector and the dot products.
    logic signed [17:0] vx_c, vy_c, wx_c, wy_c;
    seg_carry_t         s1_carry_reg;
    logic signed [35:0] pvx_reg, pvy_reg, vxx_reg, vyy_reg;

    always_comb
    begin
        vx_c = $signed({1'b0, ends.bx}) - $signed({1'b0, ends.ax});
        vy_c = $signed({1'b0, ends.by}) - $signed({1'b0, ends.ay});
        wx_c = $signed({1'b0, px}) - $signed({1'b0, ends.ax});
        wy_c = $signed({1'b0, py}) - $signed({1'b0, ends.ay});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_carry_reg <= '{ends.ax, ends.ay, vx_c, vy_c, px, py};
            pvx_reg      <= wx_c * vx_c;
            pvy_reg      <= wy_c * vy_c;
            vxx_reg      <= vx_c * vx_c;
            vyy_reg      <= vy_c * vy_c;
        end
    end

    // Stage 2: numerator, squared length and the clamp cases.
    logic signed [36:0] num_c;
    logic [36:0]        len2_c;
    logic               zero_c, one_c;

    logic [33:0] rem_reg  [0:DIV_ST];
    logic [32:0] den_reg  [0:DIV_ST];
    logic [15:0] q_reg    [0:DIV_ST];
    logic        zero_reg [0:DIV_ST];
    logic        one_reg  [0:DIV_ST];
    seg_carry_t  dcar_reg [0:DIV_ST];

    always_comb
    begin
        num_c  = 37'(pvx_reg) + 37'(pvy_reg);
        len2_c = {1'b0, vxx_reg[35:0]} + {1'b0, vyy_reg[35:0]};
        zero_c = (len2_c == 37'd0) || num_c[36] || (num_c == 37'sd0);
        one_c  = !zero_c && (num_c[35:0] >= len2_c[35:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {1'b0, num_c[32:0]};
            den_reg[0]  <= len2_c[32:0];
            q_reg[0]    <= 16'd0;
            zero_reg[0] <= zero_c;
            one_reg[0]  <= one_c;
            dcar_reg[0] <= s1_carry_reg;
        end
    end

    // Long division, two quotient bits per stage.
    for (genvar g = 0; g < DIV_ST; g++)
    begin : g_div
        logic [33:0] rem_next;
        logic [15:0] q_next;

        always_comb
        begin
            rem_next = rem_reg[g];
            q_next   = q_reg[g];
            for (int k = 0; k < DIV_PER; k++)
            begin
                rem_next = {rem_next[32:0], 1'b0};
                q_next   = {q_next[14:0], 1'b0};
                if (rem_next >= {1'b0, den_reg[g]})
                begin
                    rem_next  = rem_next - {1'b0, den_reg[g]};
                    q_next[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1]  <= rem_next;
                den_reg[g+1]  <= den_reg[g];
                q_reg[g+1]    <= q_next;
                zero_reg[g+1] <= zero_reg[g];
                one_reg[g+1]  <= one_reg[g];
                dcar_reg[g+1] <= dcar_reg[g];
            end
        end
    end

    // Closest point, first step: |v| times the projection fraction.
    seg_carry_t  fin_c;
    logic [16:0] t_c, magx_c, magy_c;
    logic [17:0] negvx_c, negvy_c;
    logic [33:0] prodx_reg, prody_reg;
    logic        negx_reg, negy_reg;
    logic [16:0] l1_ax_reg, l1_ay_reg, l1_px_reg, l1_py_reg;

    always_comb
    begin
        fin_c = dcar_reg[DIV_ST];
        if (one_reg[DIV_ST])
            t_c = 17'h10000;
        else if (zero_reg[DIV_ST])
            t_c = 17'd0;
        else
            t_c = {1'b0, q_reg[DIV_ST]};
        negvx_c = 18'(-fin_c.vx);
        negvy_c = 18'(-fin_c.vy);
        magx_c  = fin_c.vx[17] ? negvx_c[16:0] : fin_c.vx[16:0];
        magy_c  = fin_c.vy[17] ? negvy_c[16:0] : fin_c.vy[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodx_reg <= magx_c * t_c;
            prody_reg <= magy_c * t_c;
            negx_reg  <= fin_c.vx[17];
            negy_reg  <= fin_c.vy[17];
            l1_ax_reg <= fin_c.ax;
            l1_ay_reg <= fin_c.ay;
            l1_px_reg <= fin_c.px;
            l1_py_reg <= fin_c.py;
        end
    end

    // Closest point with rounding half away from zero, then the offset.
    logic [33:0]        rndx_c, rndy_c;
    logic signed [18:0] cx_c, cy_c, dx_c, dy_c;
    logic signed [17:0] dx_reg, dy_reg;

    always_comb
    begin
        rndx_c = prodx_reg + 34'd32768;
        rndy_c = prody_reg + 34'd32768;
        if (negx_reg)
            cx_c = $signed({2'b0, l1_ax_reg}) - $signed({2'b0, rndx_c[32:16]});
        else
            cx_c = $signed({2'b0, l1_ax_reg}) + $signed({2'b0, rndx_c[32:16]});
        if (negy_reg)
            cy_c = $signed({2'b0, l1_ay_reg}) - $signed({2'b0, rndy_c[32:16]});
        else
            cy_c = $signed({2'b0, l1_ay_reg}) + $signed({2'b0, rndy_c[32:16]});
        dx_c = $signed({2'b0, l1_px_reg}) - cx_c;
        dy_c = $signed({2'b0, l1_py_reg}) - cy_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_c[17:0];
            dy_reg <= dy_c[17:0];
        end
    end

    // Squares of the offsets.
    logic [17:0] adx_c, ady_c;
    logic [33:0] sqx_reg, sqy_reg;

    always_comb
    begin
        adx_c = dx_reg[17] ? 18'(-dx_reg) : dx_reg;
        ady_c = dy_reg[17] ? 18'(-dy_reg) : dy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= adx_c[16:0] * adx_c[16:0];
            sqy_reg <= ady_c[16:0] * ady_c[16:0];
        end
    end

    // Squared distance into the square root pipeline.
    logic [35:0] rad_reg  [0:SQ_ST];
    logic [21:0] srem_reg [0:SQ_ST];
    logic [17:0] root_reg [0:SQ_ST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= {2'b0, sqx_reg + sqy_reg};
            srem_reg[0] <= 22'd0;
            root_reg[0] <= 18'd0;
        end
    end

    // Integer square root, three result bits per stage.
    for (genvar g = 0; g < SQ_ST; g++)
    begin : g_sqrt
        logic [35:0] rad_next;
        logic [21:0] rem_next;
        logic [17:0] root_next;
        logic [21:0] trial;

        always_comb
        begin
            rad_next  = rad_reg[g];
            rem_next  = srem_reg[g];
            root_next = root_reg[g];
            trial     = 22'd0;
            for (int k = 0; k < SQ_PER; k++)
            begin
                rem_next = {rem_next[19:0], rad_next[35:34]};
                rad_next = {rad_next[33:0], 2'b00};
                trial    = {2'b00, root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[16:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[16:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g+1]  <= rad_next;
                srem_reg[g+1] <= rem_next;
                root_reg[g+1] <= root_next;
            end
        end
    end

    assign distance = root_reg[SQ_ST];

endmodule

[hdl/arrow_glyph_coverage.sv]
// ============================================================================
// arrow_glyph_coverage
// Anti-aliased thin-line arrow glyph coverage, one pixel per unstalled clock.
// ============================================================================
// Usage:
//   Each item on the s_ channel is one pixel (column, row) of a square cell.
//   The block returns one coverage byte per pixel on the m_ channel, in the
//   order the pixels came in. Coverage is 0 for empty and 255 for full.
//   Direction and cell size are set through the write port while no pixel
//   is in flight; the derived geometry passes the margin and wing stages
//   and the geometry register, and is read by a pixel only after it has
//   passed four input stages. One pixel is accepted every cycle unless the
//   pipeline holds; the rate is set by a single pipeline with three parallel
//   stroke units (division at two bits a stage, square root at three bits a
//   stage). When the receiver stalls, the whole pipeline holds and s_tready
//   falls only while the output register is full and not taken.
//   Reset empties the pipeline and loads direction right and cell size 128.
// ============================================================================
module arrow_glyph_coverage
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // pixel_x [7:0], pixel_y [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // coverage [7:0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int LAST = agc_pkg::PIPE_LAT - 1;
    localparam int CW   = agc_pkg::COORD_W;

    agc_pkg::geom_t geom;
    logic           adv;
    logic [LAST:0]  vld_reg;
    logic [LAST:0]  vld_next;

    logic [CW-1:0] pxq_reg [0:agc_pkg::PIX_LAT-1];
    logic [CW-1:0] pyq_reg [0:agc_pkg::PIX_LAT-1];

    logic [agc_pkg::DIST_W-1:0] stroke_dist [0:2];

    // Geometry from the configuration registers.
    agc_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // The pipeline moves when the output register is empty or being taken.
    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[LAST-1:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Pixel centers, delayed until the geometry has settled.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxq_reg[0] <= {1'b0, s_tdata[7:0], 8'h80};
            pyq_reg[0] <= {1'b0, s_tdata[15:8], 8'h80};
            for (int i = 1; i < agc_pkg::PIX_LAT; i++)
            begin
                pxq_reg[i] <= pxq_reg[i-1];
                pyq_reg[i] <= pyq_reg[i-1];
            end
        end
    end

    // One distance unit per stroke.
    for (genvar s = 0; s < 3; s++)
    begin : g_seg
        agc_seg u_seg
        (
            .clk      (clk),
            .en       (adv),
            .ends     (geom.seg[s]),
            .px       (pxq_reg[agc_pkg::PIX_LAT-1]),
            .py       (pyq_reg[agc_pkg::PIX_LAT-1]),
            .distance (stroke_dist[s])
        );
    end

    // Nearest stroke and clamped coverage.
    logic [17:0]        dmin_c;
    logic signed [19:0] cov_c;
    logic [8:0]         cov_reg;

    always_comb
    begin
        dmin_c = geom.dinit;
        for (int s = 0; s < 3; s++)
        begin
            if (stroke_dist[s] < dmin_c)
                dmin_c = stroke_dist[s];
        end
        cov_c = $signed({8'd0, geom.half}) + 20'sd128 - $signed({2'b0, dmin_c});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cov_c[19])
                cov_reg <= 9'd0;
            else if (cov_c > 20'(agc_pkg::ONE_Q))
                cov_reg <= 9'(agc_pkg::ONE_Q);
            else
                cov_reg <= cov_c[8:0];
        end
    end

    // Scale to a byte with rounding.
    logic [17:0] scaled_c;
    logic [7:0]  out_reg;

    assign scaled_c = {1'b0, cov_reg, 8'd0} - 18'(cov_reg) + 18'd128;

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= scaled_c[15:8];
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = out_reg;

    // A held pipeline keeps its occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline occupancy changed during a stall");

    // An accepted item occupies the first stage next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && adv) |=> vld_reg[0])
        else $error("accepted item lost at the input stage");

    // Coverage never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST-1] |-> (cov_reg <= 9'(agc_pkg::ONE_Q)))
        else $error("coverage above full scale");

    // A result that was shown and not taken is still shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_reg)))
        else $error("pending result changed");

endmodule

[test/agc_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// agc_checker
// Watches the pixel and coverage channels of the arrow glyph coverage block,
// computes the expected coverage byte of every accepted pixel and compares.
// ============================================================================
module agc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // pixel_x [7:0], pixel_y [15:8]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // coverage [7:0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    logic [1:0] dir_q;
    logic [8:0] size_q;
    logic [7:0] coverage_due[$];

    // Multiply by a 16-bit fraction constant, keep FRAC_BITS, round.
    function automatic longint scaled(longint n, longint k);
        return (((n * k) << agc_pkg::FRAC_BITS) + 32768) >>> 16;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Start point plus the rounded share t of the vector, half away from zero.
    function automatic longint along(longint a, longint v, longint t);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag * t + 32768) >> 16;
        return (v < 0) ? a - r : a + r;
    endfunction

    function automatic longint stroke_dist(longint px, longint py, longint ax,
                                           longint ay, longint bx, longint by);
        longint vx;
        longint vy;
        longint len2;
        longint num;
        longint t;
        longint rem;
        longint dx;
        longint dy;
        vx = bx - ax;
        vy = by - ay;
        len2 = vx * vx + vy * vy;
        num = (px - ax) * vx + (py - ay) * vy;
        t = 0;
        if (len2 > 0 && num > 0)
        begin
            if (num >= len2)
                t = 65536;
            else
            begin
                rem = num;
                for (int i = 0; i < 16; i++)
                begin
                    rem = rem << 1;
                    t = t << 1;
                    if (rem >= len2)
                    begin
                        rem = rem - len2;
                        t = t | 1;
                    end
                end
            end
        end
        dx = px - along(ax, vx, t);
        dy = py - along(ay, vy, t);
        return floor_sqrt(dx * dx + dy * dy);
    endfunction

    function automatic logic [7:0] arrow_coverage(logic [1:0] dir, logic [8:0] size,
                                                  logic [7:0] x, logic [7:0] y);
        longint n;
        longint m;
        longint half;
        longint mid;
        longint lo;
        longint hi;
        longint w;
        longint px;
        longint py;
        longint d;
        longint di;
        longint cov;
        longint sx[3];
        longint sy[3];
        longint ex[3];
        longint ey[3];
        n = size;
        if (n == 0)
            n = 1;
        if (n > agc_pkg::MAX_CELL)
            n = agc_pkg::MAX_CELL;
        m = scaled(n, agc_pkg::K_MARGIN);
        half = scaled(n, agc_pkg::K_HALF);
        mid = n * agc_pkg::ONE_Q / 2;
        lo = m;
        hi = n * agc_pkg::ONE_Q - m;
        w = ((mid - m) * agc_pkg::K_WING + 32768) >> 16;
        case (dir)
            agc_pkg::DIR_UP:
            begin
                sx = '{mid, mid, mid}; sy = '{hi, lo, lo};
                ex = '{mid, mid - w, mid + w}; ey = '{lo, lo + w, lo + w};
            end
            agc_pkg::DIR_DOWN:
            begin
                sx = '{mid, mid, mid}; sy = '{lo, hi, hi};
                ex = '{mid, mid - w, mid + w}; ey = '{hi, hi - w, hi - w};
            end
            agc_pkg::DIR_LEFT:
            begin
                sx = '{hi, lo, lo}; sy = '{mid, mid, mid};
                ex = '{lo, lo + w, lo + w}; ey = '{mid, mid - w, mid + w};
            end
            default:
            begin
                sx = '{lo, hi, hi}; sy = '{mid, mid, mid};
                ex = '{hi, hi - w, hi - w}; ey = '{mid, mid - w, mid + w};
            end
        endcase
        px = longint'(x) * agc_pkg::ONE_Q + agc_pkg::ONE_Q / 2;
        py = longint'(y) * agc_pkg::ONE_Q + agc_pkg::ONE_Q / 2;
        d = 2 * n * agc_pkg::ONE_Q;
        for (int i = 0; i < 3; i++)
        begin
            di = stroke_dist(px, py, sx[i], sy[i], ex[i], ey[i]);
            if (di < d)
                d = di;
        end
        cov = half + agc_pkg::ONE_Q / 2 - d;
        if (cov < 0)
            cov = 0;
        if (cov > agc_pkg::ONE_Q)
            cov = agc_pkg::ONE_Q;
        return 8'((cov * 255 + agc_pkg::ONE_Q / 2) >> agc_pkg::FRAC_BITS);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count = fail_count + 1;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // Track registers, queue predictions and compare results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_q = agc_pkg::DIR_RIGHT;
            size_q = 9'd128;
            coverage_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == agc_pkg::CFG_DIRECTION)
                    dir_q = cfg_data[1:0];
                else
                    size_q = cfg_data;
            end
            if (s_tvalid && s_tready)
                coverage_due.push_back(arrow_coverage(dir_q, size_q,
                                                      s_tdata[7:0], s_tdata[15:8]));
            if (m_tvalid && m_tready)
            begin
                if (coverage_due.size() == 0)
                    report_mismatch($sformatf("unexpected coverage %0d", m_tdata));
                else
                begin
                    logic [7:0] want;
                    want = coverage_due.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("coverage %0d, expected %0d",
                                                  m_tdata, want));
                end
            end
        end
        pending = coverage_due.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Streams pixels through the arrow glyph coverage block over several
// directions and cell sizes, with random idling on both channels.
// ============================================================================
module tb_top;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // pixel_x [7:0], pixel_y [15:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // coverage [7:0]
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [8:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_idle;
    bit          hold_recv;
    int          quiet;

    arrow_glyph_coverage dut (.*);

    agc_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stalls plus an optional long hold-off.
    always @(posedge clk)
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one pixel; tvalid stays high so the next pixel can follow at once.
    task automatic send_pixel(logic [7:0] x, logic [7:0] y);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [8:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (agc_pkg::PIPE_LAT + 4) @(posedge clk);
    endtask

    // Pixels mostly inside the cell, some anywhere.
    task automatic random_pixels(int count, int size);
        int lim;
        lim = (size < 1) ? 0 : ((size > 256) ? 255 : size - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8)
                send_pixel(8'($urandom_range(lim)), 8'($urandom_range(lim)));
            else
                send_pixel(8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int sizes[8];
        sizes = '{1, 256, 0, 511, 8, 16, 37, 128};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = agc_pkg::CFG_DIRECTION;
        cfg_data = '0;
        send_idle = 30;
        recv_idle = 55;
        hold_recv = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels at reset settings: corners, centre, the shaft.
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd64, 8'd64);
        send_pixel(8'd63, 8'd63);
        send_pixel(8'd17, 8'd63);
        send_pixel(8'd109, 8'd64);
        send_pixel(8'd100, 8'd40);
        send_pixel(8'd127, 8'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd170, 8'd85);
        drain();
        // Every direction once at full cell, pixel outside a tiny cell.
        for (int d = 0; d < 4; d++)
        begin
            write_reg(agc_pkg::CFG_DIRECTION, 9'(d));
            write_reg(agc_pkg::CFG_CELL_SIZE, 9'd256);
            send_pixel(8'd128, 8'd36);
            send_pixel(8'd128, 8'd219);
            send_pixel(8'd200, 8'd128);
            drain();
        end
        write_reg(agc_pkg::CFG_CELL_SIZE, 9'd0);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd200, 8'd3);
        drain();

        // Random phases: each size and direction, with changing idling.
        for (int ph = 0; ph < 24; ph++)
        begin
            if (ph == 8)
            begin
                send_idle = 55;
                recv_idle = 30;
            end
            else if (ph == 16)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(agc_pkg::CFG_DIRECTION, 9'(ph % 4));
            write_reg(agc_pkg::CFG_CELL_SIZE, 9'(sizes[ph % 8]));
            if (ph == 20)
            begin
                // Long receiver hold-off while the sender keeps pushing.
                hold_recv = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge clk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            random_pixels(75, sizes[ph % 8]);
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/agc_pkg.sv
hdl/agc_geom.sv
hdl/agc_seg.sv
hdl/arrow_glyph_coverage.sv
test/agc_checker.sv
test/tb_top.sv
